// ===== rtl/breakpoint_read_classifier_core_defines.svh =====
// Assertion macros used by the port-level checker of the breakpoint read classifier.
`ifndef BREAKPOINT_READ_CLASSIFIER_CORE_DEFINES_SVH
`define BREAKPOINT_READ_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BRC_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("brc: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define BRC_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("brc: next-cycle check failed");

`endif

// ===== rtl/brc_pkg.sv =====
// Shared constants, codes and types of the breakpoint read classifier.
package brc_pkg;

  localparam int COUNT_BITS_DEFAULT = 24;
  localparam int QUEUE_DEPTH        = 4;

  localparam int NODE_W  = 16;
  localparam int MATCH_W = 12;
  localparam int RLEN_W  = 12;
  localparam int MM_W    = 11;
  localparam int SUM_W   = 16;
  localparam int COV_W   = 44;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;
  localparam int FRAC_W  = 8;

  localparam logic [MM_W-1:0]  MIN_MATCH_RESET = MM_W'(10);
  localparam logic [COV_W-1:0] COV_MAX         = '1;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_FIRST_VARIANT = 2'd0;
  localparam logic [IDX_W-1:0] REG_LAST_VARIANT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_MATCH     = 2'd2;

  // Input item modes and result kinds.
  localparam logic MODE_NODE   = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;
  localparam logic KIND_CLASS  = 1'b0;
  localparam logic KIND_STATS  = 1'b1;

  localparam logic [1:0] CLASS_NONE = 2'd0;

  // Header of one queue entry; the two read counts follow it.
  typedef struct packed {
    logic              kind;
    logic [1:0]        flank_class;
    logic              div_err;
    logic [RLEN_W-1:0] read_length;
    logic [RLEN_W-1:0] divisor;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

endpackage

// ===== rtl/brc_queue.sv =====
// Small first-in first-out queue between the classifier front and back.
module brc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = brc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;

  assign empty    = (wr_ptr == rd_ptr);
  assign full     = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign pop_data = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr[AW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/brc_front.sv =====
// Front part: configuration registers, flank sums, read classification and counters.
module brc_front #(
  parameter int COUNT_BITS = brc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [brc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [brc_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic [brc_pkg::NODE_W-1:0]         node_id,
  input  logic [brc_pkg::MATCH_W-1:0]        match_count,
  input  logic                               last_node,
  input  logic [brc_pkg::RLEN_W-1:0]         read_length,
  output logic                               q_push,
  output logic [brc_pkg::HDR_W+2*COUNT_BITS-1:0] q_data,
  input  logic                               q_full
);

  localparam int SW = brc_pkg::SUM_W;

  logic [brc_pkg::NODE_W-1:0] first_variant;
  logic [brc_pkg::NODE_W-1:0] last_variant;
  logic [brc_pkg::MM_W-1:0]   min_match;

  logic [SW-1:0]         left_sum, var_sum, right_sum;
  logic [COUNT_BITS-1:0] left_cnt, right_cnt;

  logic                  accept;
  logic                  in_left, in_var, in_right;
  logic [SW:0]           l_add, v_add, r_add;
  logic [SW-1:0]         left_new, var_new, right_new;
  logic [SW:0]           vr_sum, vl_sum;
  logic                  sup_left, sup_right;
  logic [COUNT_BITS-1:0] left_cnt_inc, right_cnt_inc;
  logic [brc_pkg::RLEN_W-1:0] twice_mm;
  logic                  div_err;
  brc_pkg::hdr_t         hdr;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_left  = node_id < first_variant;
    in_var   = !in_left && (node_id <= last_variant);
    in_right = !in_left && !in_var;

    l_add = {1'b0, left_sum}  + (SW+1)'(match_count);
    v_add = {1'b0, var_sum}   + (SW+1)'(match_count);
    r_add = {1'b0, right_sum} + (SW+1)'(match_count);

    // Sums saturate at all ones.
    left_new  = !in_left  ? left_sum  : (l_add[SW] ? '1 : l_add[SW-1:0]);
    var_new   = !in_var   ? var_sum   : (v_add[SW] ? '1 : v_add[SW-1:0]);
    right_new = !in_right ? right_sum : (r_add[SW] ? '1 : r_add[SW-1:0]);

    vr_sum = {1'b0, var_new} + {1'b0, right_new};
    vl_sum = {1'b0, var_new} + {1'b0, left_new};

    sup_left  = (left_new >= SW'(min_match))  && (vr_sum >= (SW+1)'(min_match));
    sup_right = (right_new >= SW'(min_match)) && (vl_sum >= (SW+1)'(min_match));

    left_cnt_inc  = (&left_cnt)  ? left_cnt  : left_cnt  + 1'b1;
    right_cnt_inc = (&right_cnt) ? right_cnt : right_cnt + 1'b1;

    twice_mm = {min_match, 1'b0};
    div_err  = read_length <= twice_mm;

    hdr.read_length = read_length;
    hdr.divisor     = read_length - twice_mm;
    if (mode == brc_pkg::MODE_QUERY) begin
      hdr.kind        = brc_pkg::KIND_STATS;
      hdr.flank_class = brc_pkg::CLASS_NONE;
      hdr.div_err     = div_err;
    end else begin
      hdr.kind        = brc_pkg::KIND_CLASS;
      hdr.flank_class = {sup_right, sup_left};
      hdr.div_err     = 1'b0;
    end
  end

  // A query snapshots the counters as they stand before any later read.
  assign q_push = accept && ((mode == brc_pkg::MODE_QUERY) || last_node);
  assign q_data = {hdr, left_cnt, right_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_variant <= '0;
      last_variant  <= '0;
      min_match     <= brc_pkg::MIN_MATCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        brc_pkg::REG_FIRST_VARIANT: first_variant <= cfg_data;
        brc_pkg::REG_LAST_VARIANT:  last_variant  <= cfg_data;
        brc_pkg::REG_MIN_MATCH:     min_match     <= cfg_data[brc_pkg::MM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum  <= '0;
      var_sum   <= '0;
      right_sum <= '0;
      left_cnt  <= '0;
      right_cnt <= '0;
    end else if (accept && (mode == brc_pkg::MODE_NODE)) begin
      if (last_node) begin
        left_sum  <= '0;
        var_sum   <= '0;
        right_sum <= '0;
        if (sup_left) begin
          left_cnt <= left_cnt_inc;
        end
        if (sup_right) begin
          right_cnt <= right_cnt_inc;
        end
      end else begin
        left_sum  <= left_new;
        var_sum   <= var_new;
        right_sum <= right_new;
      end
    end
  end

endmodule

// ===== rtl/brc_back.sv =====
// Back part: result register and the bit-serial coverage dividers.
module brc_back #(
  parameter int COUNT_BITS = brc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [brc_pkg::HDR_W+2*COUNT_BITS-1:0]  q_data,
  input  logic                                    q_empty,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    kind,
  output logic [1:0]                              flank_class,
  output logic [brc_pkg::COV_W-1:0]               left_coverage,
  output logic [brc_pkg::COV_W-1:0]               right_coverage,
  output logic                                    divisor_error
);

  localparam int RW    = brc_pkg::RLEN_W;
  localparam int CW    = brc_pkg::COV_W;
  localparam int NUM_W = COUNT_BITS + RW + brc_pkg::FRAC_W;
  localparam int QW    = (NUM_W > CW) ? NUM_W : CW;
  localparam int STW   = $clog2(NUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]            state, state_next;
  logic [STW-1:0]        step;
  brc_pkg::hdr_t         hdr;
  logic [COUNT_BITS-1:0] head_cnt [2];
  logic [COUNT_BITS-1:0] cnt [2];
  logic [RW-1:0]         rlen;
  logic [RW-1:0]         divisor;
  logic [NUM_W-1:0]      dvd [2];
  logic [RW-1:0]         rem [2];
  logic [NUM_W-1:0]      dvd_next [2];
  logic [RW-1:0]         rem_next [2];
  logic [CW-1:0]         cov [2];
  logic                  out_free;
  logic                  direct;

  assign hdr         = brc_pkg::hdr_t'(q_data[brc_pkg::HDR_W+2*COUNT_BITS-1 -: brc_pkg::HDR_W]);
  assign head_cnt[0] = q_data[2*COUNT_BITS-1:COUNT_BITS];
  assign head_cnt[1] = q_data[COUNT_BITS-1:0];

  assign out_free = !out_valid || !out_stall;
  // Classifications and failed queries go straight to the result register.
  assign direct   = (hdr.kind == brc_pkg::KIND_CLASS) || hdr.div_err;
  assign q_pop    = (state == ST_IDLE) && !q_empty && (!direct || out_free);

  // One restoring-division step per lane and cycle.
  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [RW:0] trial;
    logic        ge;
    logic [QW-1:0] qx;
    always_comb begin
      trial       = {rem[g], dvd[g][NUM_W-1]};
      ge          = trial >= {1'b0, divisor};
      rem_next[g] = ge ? RW'(trial - {1'b0, divisor}) : trial[RW-1:0];
      dvd_next[g] = {dvd[g][NUM_W-2:0], ge};
      qx          = QW'(dvd[g]);
      cov[g]      = (qx > QW'(brc_pkg::COV_MAX)) ? brc_pkg::COV_MAX : qx[CW-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_pop && !direct) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (step == STW'(NUM_W - 1)) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_IDLE && q_pop && direct) || (state == ST_DONE && out_free)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          cnt[0]  <= head_cnt[0];
          cnt[1]  <= head_cnt[1];
          rlen    <= hdr.read_length;
          divisor <= hdr.divisor;
          if (direct) begin
            kind           <= hdr.kind;
            flank_class    <= hdr.flank_class;
            divisor_error  <= hdr.div_err;
            left_coverage  <= '0;
            right_coverage <= '0;
          end
        end
      end
      ST_MUL: begin
        step <= '0;
        for (int i = 0; i < 2; i++) begin
          dvd[i] <= {(COUNT_BITS + RW)'(cnt[i] * rlen), brc_pkg::FRAC_W'(0)};
          rem[i] <= '0;
        end
      end
      ST_DIV: begin
        step <= step + 1'b1;
        for (int i = 0; i < 2; i++) begin
          dvd[i] <= dvd_next[i];
          rem[i] <= rem_next[i];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          kind           <= brc_pkg::KIND_STATS;
          flank_class    <= brc_pkg::CLASS_NONE;
          divisor_error  <= 1'b0;
          left_coverage  <= cov[0];
          right_coverage <= cov[1];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/breakpoint_read_classifier_core.sv =====
// Top level of the breakpoint read classifier: front, queue and back joined.
//
// Input channel (in_valid / in_stall): one transfer per alignment node record
// (mode 0) or coverage query (mode 1). Node records are taken one per cycle
// while the queue has room; a record that is not the last node of its read
// gives no result.
// Output channel (out_valid / out_stall): one transfer per classification or
// query result. A classification passes through the queue and then the
// result register after its last node is taken. A coverage query passes the
// queue; the back part then forms the count times read length product, runs
// the two bit-serial restoring dividers, which work in parallel, and loads
// the result register; a query whose divisor is not positive takes the
// short path like a classification.
// The four-entry queue between front and back lets node records keep
// streaming while a query divides; the front stalls only when it is full.
// When the receiver stalls, the result register holds its transfer and the
// back part waits; the queue then fills and in_stall rises.
// Synchronous reset clears the sums, the read counters, the queue and the
// result valid flag and loads the register defaults (min_match is 10).
// Configuration writes through cfg_we / cfg_index / cfg_data take effect at
// the next edge and must only be made while the block is idle.
module breakpoint_read_classifier_core #(
  parameter int COUNT_BITS = brc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [brc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [brc_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [brc_pkg::NODE_W-1:0]  node_id,
  input  logic [brc_pkg::MATCH_W-1:0] match_count,
  input  logic                        last_node,
  input  logic [brc_pkg::RLEN_W-1:0]  read_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        kind,
  output logic [1:0]                  flank_class,
  output logic [brc_pkg::COV_W-1:0]   left_coverage,
  output logic [brc_pkg::COV_W-1:0]   right_coverage,
  output logic                        divisor_error
);

  localparam int ENTRY_W = brc_pkg::HDR_W + 2 * COUNT_BITS;

  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_full;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_pop_data;
  logic               q_empty;

  // Sums, counters and classification; one entry per result.
  brc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .node_id     (node_id),
    .match_count (match_count),
    .last_node   (last_node),
    .read_length (read_length),
    .q_push      (q_push),
    .q_data      (q_push_data),
    .q_full      (q_full)
  );

  brc_queue #(.WIDTH(ENTRY_W), .DEPTH(brc_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Coverage division and the output register.
  brc_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_data         (q_pop_data),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .flank_class    (flank_class),
    .left_coverage  (left_coverage),
    .right_coverage (right_coverage),
    .divisor_error  (divisor_error)
  );

endmodule

// ===== rtl/brc_checker.sv =====
// Port-level checks of the breakpoint read classifier and their bind.
`include "breakpoint_read_classifier_core_defines.svh"

module brc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      kind,
  input logic [1:0]                flank_class,
  input logic [brc_pkg::COV_W-1:0] left_coverage,
  input logic [brc_pkg::COV_W-1:0] right_coverage,
  input logic                      divisor_error
);

  logic [2*brc_pkg::COV_W+3:0] out_payload;
  logic                        is_class;
  logic                        is_stats;
  logic                        cov_zero;

  assign out_payload = {kind, flank_class, left_coverage, right_coverage, divisor_error};
  assign is_class    = out_valid && (kind == brc_pkg::KIND_CLASS);
  assign is_stats    = out_valid && (kind == brc_pkg::KIND_STATS);
  assign cov_zero    = (left_coverage == '0) && (right_coverage == '0);

  // A stalled result is held unchanged.
  `BRC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_payload))

  // Classifications carry no coverage and no error.
  `BRC_ASSERT_IMP(a_class_clean, clk, rst, is_class, cov_zero && !divisor_error)

  // Coverage results carry no flank class.
  `BRC_ASSERT_IMP(a_stats_no_class, clk, rst, is_stats, flank_class == brc_pkg::CLASS_NONE)

  // A failed divisor yields zero coverage.
  `BRC_ASSERT_IMP(a_err_zero, clk, rst, out_valid && divisor_error, is_stats && cov_zero)

endmodule

bind breakpoint_read_classifier_core brc_checker u_brc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .kind           (kind),
  .flank_class    (flank_class),
  .left_coverage  (left_coverage),
  .right_coverage (right_coverage),
  .divisor_error  (divisor_error)
);

// ===== bench/breakpoint_read_checker.sv =====
// Checker of the breakpoint read classifier: predicts every result and compares it.
module breakpoint_read_checker #(
  parameter int COUNT_BITS = brc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [brc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [brc_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        mode,
  input  logic [brc_pkg::NODE_W-1:0]  node_id,
  input  logic [brc_pkg::MATCH_W-1:0] match_count,
  input  logic                        last_node,
  input  logic [brc_pkg::RLEN_W-1:0]  read_length,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        kind,
  input  logic [1:0]                  flank_class,
  input  logic [brc_pkg::COV_W-1:0]   left_coverage,
  input  logic [brc_pkg::COV_W-1:0]   right_coverage,
  input  logic                        divisor_error,
  output int                          mismatches,
  output int                          awaiting,
  output int                          node_records,
  output int                          queries,
  output int                          classifications,
  output int                          divisor_errors
);

  typedef struct packed {
    logic                      kind;
    logic [1:0]                flank_class;
    logic [brc_pkg::COV_W-1:0] left_cov;
    logic [brc_pkg::COV_W-1:0] right_cov;
    logic                      div_err;
  } outcome_t;

  logic [brc_pkg::NODE_W-1:0] first_var;
  logic [brc_pkg::NODE_W-1:0] last_var;
  logic [brc_pkg::MM_W-1:0]   min_bases;
  logic [brc_pkg::SUM_W-1:0]  left_sum;
  logic [brc_pkg::SUM_W-1:0]  var_sum;
  logic [brc_pkg::SUM_W-1:0]  right_sum;
  logic [COUNT_BITS-1:0]      left_reads;
  logic [COUNT_BITS-1:0]      right_reads;
  outcome_t                   awaited_results[$];

  function automatic logic [brc_pkg::SUM_W-1:0] clamp_add(
      input logic [brc_pkg::SUM_W-1:0] total, input logic [brc_pkg::MATCH_W-1:0] extra);
    logic [brc_pkg::SUM_W:0] wide;
    wide = {1'b0, total} + (brc_pkg::SUM_W+1)'(extra);
    return wide[brc_pkg::SUM_W] ? {brc_pkg::SUM_W{1'b1}} : wide[brc_pkg::SUM_W-1:0];
  endfunction

  function automatic logic [brc_pkg::COV_W-1:0] coverage_fixed(
      input logic [COUNT_BITS-1:0] reads, input logic [brc_pkg::RLEN_W-1:0] rlen,
      input logic [brc_pkg::RLEN_W-1:0] div);
    logic [63:0] quot;
    quot = ((64'(reads) * 64'(rlen)) << brc_pkg::FRAC_W) / 64'(div);
    return (quot > 64'(brc_pkg::COV_MAX)) ? brc_pkg::COV_MAX : quot[brc_pkg::COV_W-1:0];
  endfunction

  task automatic answer_coverage_query(input logic [brc_pkg::RLEN_W-1:0] rlen);
    outcome_t                   res;
    logic [brc_pkg::RLEN_W-1:0] twice_min;
    res = '0;
    res.kind = brc_pkg::KIND_STATS;
    res.flank_class = brc_pkg::CLASS_NONE;
    twice_min = {min_bases, 1'b0};
    if (rlen <= twice_min) begin
      res.div_err = 1'b1;
    end else begin
      res.left_cov  = coverage_fixed(left_reads, rlen, rlen - twice_min);
      res.right_cov = coverage_fixed(right_reads, rlen, rlen - twice_min);
    end
    awaited_results = {awaited_results, res};
  endtask

  task automatic classify_node_record(input logic [brc_pkg::NODE_W-1:0] nid,
                                      input logic [brc_pkg::MATCH_W-1:0] bases,
                                      input logic closes_read);
    outcome_t res;
    logic     backs_left;
    logic     backs_right;
    if (nid < first_var) left_sum = clamp_add(left_sum, bases);
    else if (nid <= last_var) var_sum = clamp_add(var_sum, bases);
    else right_sum = clamp_add(right_sum, bases);
    if (closes_read) begin
      // Each breakpoint needs enough matched bases on both of its sides.
      backs_left  = (left_sum >= brc_pkg::SUM_W'(min_bases)) &&
                    (int'(var_sum) + int'(right_sum) >= int'(min_bases));
      backs_right = (int'(var_sum) + int'(left_sum) >= int'(min_bases)) &&
                    (right_sum >= brc_pkg::SUM_W'(min_bases));
      if (backs_left && left_reads != '1) left_reads = left_reads + 1'b1;
      if (backs_right && right_reads != '1) right_reads = right_reads + 1'b1;
      left_sum  = '0;
      var_sum   = '0;
      right_sum = '0;
      res = '0;
      res.kind = brc_pkg::KIND_CLASS;
      res.flank_class = {backs_right, backs_left};
      awaited_results = {awaited_results, res};
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      first_var   = '0;
      last_var    = '0;
      min_bases   = brc_pkg::MIN_MATCH_RESET;
      left_sum    = '0;
      var_sum     = '0;
      right_sum   = '0;
      left_reads  = '0;
      right_reads = '0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          brc_pkg::REG_FIRST_VARIANT: first_var = cfg_data[brc_pkg::NODE_W-1:0];
          brc_pkg::REG_LAST_VARIANT:  last_var  = cfg_data[brc_pkg::NODE_W-1:0];
          brc_pkg::REG_MIN_MATCH:     min_bases = cfg_data[brc_pkg::MM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no prediction pending (kind %0d)", kind);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(kind));
          check_field("flank_class", 64'(want.flank_class), 64'(flank_class));
          check_field("left_coverage", 64'(want.left_cov), 64'(left_coverage));
          check_field("right_coverage", 64'(want.right_cov), 64'(right_coverage));
          check_field("divisor_error", 64'(want.div_err), 64'(divisor_error));
          if (want.kind == brc_pkg::KIND_CLASS) classifications++;
          else if (want.div_err) divisor_errors++;
        end
      end
      if (in_valid && !in_stall) begin
        if (mode == brc_pkg::MODE_QUERY) begin
          queries++;
          answer_coverage_query(read_length);
        end else begin
          node_records++;
          classify_node_record(node_id, match_count, last_node);
        end
      end
    end
    awaiting = awaited_results.size();
  end

endmodule

// ===== bench/tb_breakpoint_read_classifier_core.sv =====
// Testbench top of the breakpoint read classifier: stimulus, idling and the verdict.
module tb_breakpoint_read_classifier_core;

  // Index 3 names no register; writes to it must leave the block unchanged.
  localparam logic [brc_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
  // Quiet cycles before a register write; they outlast a coverage query in the
  // back part, so any node record still in flight has settled.
  localparam int SETTLE_CYCLES = brc_pkg::COUNT_BITS_DEFAULT + 40;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 153;

  typedef enum logic [1:0] {REGION_LEFT, REGION_VARIANT, REGION_RIGHT} region_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [brc_pkg::IDX_W-1:0]   cfg_index;
  logic [brc_pkg::CFG_W-1:0]   cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic                        mode;
  logic [brc_pkg::NODE_W-1:0]  node_id;
  logic [brc_pkg::MATCH_W-1:0] match_count;
  logic                        last_node;
  logic [brc_pkg::RLEN_W-1:0]  read_length;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        kind;
  logic [1:0]                  flank_class;
  logic [brc_pkg::COV_W-1:0]   left_coverage;
  logic [brc_pkg::COV_W-1:0]   right_coverage;
  logic                        divisor_error;

  int mismatches;
  int awaiting;
  int node_records;
  int queries;
  int classifications;
  int divisor_errors;

  // Idling knobs: percent chance per transfer of a sender gap, and per cycle
  // of a receiver stall burst. Both are zero in the closing phase.
  int gap_pct;
  int stall_pct;
  int stall_left;
  int settings_used;

  // The current register setting, kept here to aim node ids, counts and read lengths.
  logic [brc_pkg::NODE_W-1:0] cur_first;
  logic [brc_pkg::NODE_W-1:0] cur_last;
  logic [brc_pkg::MM_W-1:0]   cur_min;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  breakpoint_read_classifier_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .node_id        (node_id),
    .match_count    (match_count),
    .last_node      (last_node),
    .read_length    (read_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .flank_class    (flank_class),
    .left_coverage  (left_coverage),
    .right_coverage (right_coverage),
    .divisor_error  (divisor_error)
  );

  breakpoint_read_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .node_id         (node_id),
    .match_count     (match_count),
    .last_node       (last_node),
    .read_length     (read_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .flank_class     (flank_class),
    .left_coverage   (left_coverage),
    .right_coverage  (right_coverage),
    .divisor_error   (divisor_error),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .node_records    (node_records),
    .queries         (queries),
    .classifications (classifications),
    .divisor_errors  (divisor_errors)
  );

  // Receiver side: stall comes in random bursts. A burst that is
  // under way when stalling is switched off still runs to its end.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(13);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Presents one item at a falling edge, after an optional gap, and returns
  // at the rising edge where the transfer happens. The payload is held while
  // in_stall is high. The caller either sends the next item or drops valid
  // at the very next falling edge, so an item is never taken twice.
  task automatic send_item(input logic m, input logic [brc_pkg::NODE_W-1:0] nid,
                           input logic [brc_pkg::MATCH_W-1:0] bases, input logic closes,
                           input logic [brc_pkg::RLEN_W-1:0] rlen);
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid    = 1'b1;
    mode        = m;
    node_id     = nid;
    match_count = bases;
    last_node   = closes;
    read_length = rlen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Register writes happen only with the block idle: every predicted result
  // has come out and any trailing node record has had time to settle.
  task automatic write_reg(input logic [brc_pkg::IDX_W-1:0] idx,
                           input logic [brc_pkg::CFG_W-1:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Writes all three registers plus the unused index. The min_match write
  // carries random junk above bit 10, which the block must drop.
  task automatic apply_setting(input logic [brc_pkg::NODE_W-1:0] lo,
                               input logic [brc_pkg::NODE_W-1:0] hi,
                               input logic [brc_pkg::MM_W-1:0] bases);
    logic [brc_pkg::CFG_W-1:0] junk;
    junk = brc_pkg::CFG_W'($urandom);
    write_reg(brc_pkg::REG_FIRST_VARIANT, lo);
    write_reg(brc_pkg::REG_LAST_VARIANT, hi);
    write_reg(brc_pkg::REG_MIN_MATCH, {junk[brc_pkg::CFG_W-1:brc_pkg::MM_W], bases});
    write_reg(REG_UNUSED, brc_pkg::CFG_W'($urandom));
    cur_first = lo;
    cur_last  = hi;
    cur_min   = bases;
    settings_used++;
  endtask

  // One well-formed alignment of len nodes, the last one flagged. A heavy
  // read piles maximum counts into one region to drive its sum into
  // saturation, with a couple of free nodes at the end.
  task automatic random_read(input int len, input bit heavy);
    region_t                     heavy_region;
    region_t                     region;
    logic [brc_pkg::NODE_W-1:0]  nid;
    logic [brc_pkg::MATCH_W-1:0] bases;
    bit                          at_bound;
    int                          span;
    heavy_region = region_t'($urandom_range(2));
    for (int k = 0; k < len; k++) begin
      region   = (heavy && k < len - 2) ? heavy_region : region_t'($urandom_range(2));
      at_bound = ($urandom_range(3) == 0);
      case (region)
        REGION_LEFT: begin
          if (cur_first == '0) nid = brc_pkg::NODE_W'($urandom);
          else if (at_bound) nid = cur_first - 1'b1;
          else nid = brc_pkg::NODE_W'($urandom_range(cur_first - 1, 0));
        end
        REGION_VARIANT: begin
          if (cur_first > cur_last) nid = brc_pkg::NODE_W'($urandom);
          else if (at_bound) nid = $urandom_range(1) ? cur_first : cur_last;
          else nid = brc_pkg::NODE_W'($urandom_range(cur_last, cur_first));
        end
        default: begin
          if (cur_last == '1) nid = brc_pkg::NODE_W'($urandom);
          else if (at_bound) nid = cur_last + 1'b1;
          else nid = brc_pkg::NODE_W'($urandom_range(16'hFFFF, cur_last + 1));
        end
      endcase
      // Most counts sit near the threshold so that every class shows up.
      span = 2 * cur_min + 4;
      if (span > 4095) span = 4095;
      case ($urandom_range(9))
        0:       bases = '0;
        1:       bases = '1;
        2, 3:    bases = brc_pkg::MATCH_W'($urandom);
        default: bases = brc_pkg::MATCH_W'($urandom_range(span));
      endcase
      if (heavy) bases = '1;
      send_item(brc_pkg::MODE_NODE, nid, bases, k == len - 1, brc_pkg::RLEN_W'($urandom));
    end
  endtask

  initial begin
    int                         sent;
    int                         len;
    int                         pick;
    int                         twice;
    int                         hi_wide;
    int                         waited;
    logic [brc_pkg::NODE_W-1:0] lo;
    logic [brc_pkg::RLEN_W-1:0] rlen;

    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    mode        = brc_pkg::MODE_NODE;
    node_id     = '0;
    match_count = '0;
    last_node   = 1'b0;
    read_length = '0;
    gap_pct     = 0;
    stall_pct   = 0;
    settings_used = 1;
    cur_first   = '0;
    cur_last    = '0;
    cur_min     = brc_pkg::MIN_MATCH_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset setting (variant range is node 0 only,
    // min_match 10). Queries with empty counters: zero read length, a read
    // length exactly twice min_match (divisor zero), one above it and the
    // largest read length.
    send_item(brc_pkg::MODE_QUERY, '1, '1, 1'b1, '0);
    send_item(brc_pkg::MODE_QUERY, '0, '0, 1'b0, brc_pkg::RLEN_W'(20));
    send_item(brc_pkg::MODE_QUERY, '1, '0, 1'b1, brc_pkg::RLEN_W'(21));
    send_item(brc_pkg::MODE_QUERY, '0, '1, 1'b0, '1);
    // Full counts at the lowest and highest node ids, a right-only read;
    // then a single-node read with nothing matched.
    send_item(brc_pkg::MODE_NODE, '0, '1, 1'b0, '1);
    send_item(brc_pkg::MODE_NODE, '1, '1, 1'b1, '0);
    send_item(brc_pkg::MODE_NODE, '0, '0, 1'b1, '1);

    apply_setting(16'd100, 16'd200, 11'd20);
    // A read spanning both breakpoints.
    send_item(brc_pkg::MODE_NODE, 16'd50, 12'd30, 1'b0, '0);
    send_item(brc_pkg::MODE_NODE, 16'd150, 12'd5, 1'b0, '0);
    send_item(brc_pkg::MODE_NODE, 16'd300, 12'd25, 1'b1, '0);
    // Left breakpoint only, with nodes on both sides of the first variant bound.
    send_item(brc_pkg::MODE_NODE, 16'd99, 12'd20, 1'b0, '0);
    send_item(brc_pkg::MODE_NODE, 16'd100, 12'd20, 1'b1, '0);
    // Right breakpoint only.
    send_item(brc_pkg::MODE_NODE, 16'd200, 12'd20, 1'b0, '0);
    send_item(brc_pkg::MODE_NODE, 16'd201, 12'd20, 1'b1, '0);
    // Coverage with nonzero counters: divisor zero, divisor one, widest.
    send_item(brc_pkg::MODE_QUERY, '0, '0, 1'b0, brc_pkg::RLEN_W'(40));
    send_item(brc_pkg::MODE_QUERY, '0, '0, 1'b0, brc_pkg::RLEN_W'(41));
    send_item(brc_pkg::MODE_QUERY, '0, '0, 1'b0, '1);

    // Random phases, each under its own register setting: normal range,
    // all ids in the variant region with min_match 0, inverted ranges, the
    // largest min_match, the reset setting, random ones, and a closing phase
    // with no idling at all.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_setting(16'd1000, 16'd2000, 11'd30);
        1: apply_setting(16'd0, 16'hFFFF, 11'd0);
        2: apply_setting(16'hFFFF, 16'd0, 11'h7FF);
        3: apply_setting(16'd40000, 16'd20000, 11'd7);
        4: apply_setting(16'd0, 16'd0, brc_pkg::MIN_MATCH_RESET);
        PHASES - 1: apply_setting(16'd500, 16'd900, 11'd25);
        default: begin
          lo = brc_pkg::NODE_W'($urandom);
          hi_wide = int'(lo) + $urandom_range(3000);
          if (hi_wide > 65535) hi_wide = 65535;
          apply_setting(lo, brc_pkg::NODE_W'(hi_wide), brc_pkg::MM_W'($urandom_range(60)));
        end
      endcase
      if (p == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case (p % 4)
          0:       begin gap_pct = 12; stall_pct = 12; end
          1:       begin gap_pct = 0;  stall_pct = 25; end
          2:       begin gap_pct = 30; stall_pct = 0;  end
          default: begin gap_pct = 0;  stall_pct = 0;  end
        endcase
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          // Coverage query; read lengths cluster around twice min_match,
          // where the divisor turns from zero to positive.
          twice = 2 * cur_min;
          case ($urandom_range(3))
            0: rlen = brc_pkg::RLEN_W'($urandom);
            1: rlen = brc_pkg::RLEN_W'(twice > 4095 ? 4095 : twice);
            2: rlen = brc_pkg::RLEN_W'(twice + 1 > 4095 ? 4095 : twice + 1);
            default: rlen = brc_pkg::RLEN_W'($urandom_range(twice > 4095 ? 4095 : twice));
          endcase
          send_item(brc_pkg::MODE_QUERY, brc_pkg::NODE_W'($urandom),
                    brc_pkg::MATCH_W'($urandom), 1'($urandom), rlen);
          sent++;
        end else if (pick < 12) begin
          // Stray record with random content; it may split or end a read.
          send_item(brc_pkg::MODE_NODE, brc_pkg::NODE_W'($urandom),
                    brc_pkg::MATCH_W'($urandom), 1'($urandom),
                    brc_pkg::RLEN_W'($urandom));
          sent++;
        end else if (pick < 15) begin
          len = $urandom_range(17, 20);
          random_read(len, 1'b1);
          sent += len;
        end else begin
          len = $urandom_range(1, 8);
          random_read(len, 1'b0);
          sent += len;
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    waited = 0;
    while (awaiting != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d node records and %0d coverage queries under %0d settings.",
             node_records, queries, settings_used);
    $display("Checked %0d read classes and %0d coverage results, %0d of them divisor errors.",
             classifications, queries - awaiting, divisor_errors);
    if (awaiting != 0) $error("%0d predicted results never came out", awaiting);
    if (mismatches == 0 && awaiting == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
